FILE: hw/rtl/ssrp_pkg.sv
// ============================================================================
// ssrp_pkg: shared types and codes for the slot set with root prune
// Request codes, the token handed from cell to cell, and the per-request
// broadcast that every cell of the chain sees.
// ============================================================================
package ssrp_pkg;

    localparam int unsigned SLOT_W = 64;

    localparam logic [1:0] REQ_LOOKUP   = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_PRUNE    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Token that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic tok;        // the request is at this cell now
        logic hit;        // some earlier cell holds the slot
        logic free_seen;  // some earlier cell is free
    } token_t;

    // Request data broadcast to every cell.
    typedef struct packed {
        logic              prune;
        logic              commit;
        logic [SLOT_W-1:0] value;
    } bcast_t;

endpackage

FILE: hw/rtl/ssrp_req_if.sv
// ============================================================================
// ssrp_req_if: request channel of the slot set
// Valid/ready channel carrying the request type and the slot number.
// ============================================================================
interface ssrp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] slot_value;

    modport source (output valid, output req_type, output slot_value, input ready);
    modport sink   (input valid, input req_type, input slot_value, output ready);
endinterface

FILE: hw/rtl/ssrp_rsp_if.sv
// ============================================================================
// ssrp_rsp_if: response channel of the slot set
// Valid/ready channel carrying the found and full drop flags.
// ============================================================================
interface ssrp_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic full_drop;

    modport source (output valid, output found, output full_drop, input ready);
    modport sink   (input valid, input found, input full_drop, output ready);
endinterface

FILE: hw/rtl/ssrp_cell.sv
// ============================================================================
// ssrp_cell: one entry of the slot set
// Holds one key and its valid bit, updates the token as it passes and
// remembers whether it is the first free entry for a pending add.
// ============================================================================
module ssrp_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  ssrp_pkg::bcast_t b,
    input  ssrp_pkg::token_t tok_in,
    output ssrp_pkg::token_t tok_out
);
    import ssrp_pkg::*;

    logic              valid_reg;
    logic              cand_reg;
    logic [SLOT_W-1:0] key_reg;
    token_t            tok_reg;
    logic              hit_here;
    logic              below;

    assign hit_here = valid_reg && (key_reg == b.value);
    assign below    = valid_reg && (key_reg < b.value);
    assign tok_out  = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg.tok       <= tok_in.tok;
            tok_reg.hit       <= tok_in.hit | hit_here;
            tok_reg.free_seen <= tok_in.free_seen | ~valid_reg;
            if (tok_in.tok)
            begin
                // Only the lowest free entry may take the new key.
                cand_reg <= ~valid_reg & ~tok_in.free_seen;
                if (b.prune && below)
                begin
                    valid_reg <= 1'b0;
                end
            end
            else if (b.commit && cand_reg)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b.commit && cand_reg)
        begin
            key_reg <= b.value;
        end
    end

endmodule

FILE: hw/rtl/slot_set_with_root_prune_core.sv
// ============================================================================
// slot_set_with_root_prune_core: bounded set of 64-bit slot numbers
// A chain of cells that answers lookup, add and prune-below-root requests.
// ============================================================================
// Usage:
// Requests arrive on the req channel (req_type, slot_value) and each one gives
// exactly one response on the rsp channel (found, full_drop). A lookup reports
// whether the slot is held. An add stores the slot in the lowest free entry
// unless it is already held; with no free entry the slot is dropped and
// full_drop is set. A prune clears every held slot strictly below the root
// given in slot_value; found then tells whether the root itself is held.
// The unused request code behaves as a lookup.
// Each request walks down the chain of ENTRIES cells, one cell per cycle,
// collecting the hit and the first free entry on the way. An add is written
// into the chosen cell in the cycle the response is loaded.
// The request is registered, its token walks the cell chain, and the walk
// result is captured as the walk ends and then loaded into the response
// register; no new request is taken until then. The response sits in an
// output register, so a new request is accepted while an earlier response
// still waits to be taken. If the receiver stalls, the finished request
// holds until the output register frees up. Reset empties the set at once.
// ============================================================================
module slot_set_with_root_prune_core #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    ssrp_req_if.sink     req,
    ssrp_rsp_if.source   rsp
);
    import ssrp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic              start_reg;
    logic [1:0]        kind_reg;
    logic [SLOT_W-1:0] value_reg;
    logic              hit_reg;
    logic              free_reg;
    logic              rsp_valid_reg;
    logic              found_reg;
    logic              drop_reg;

    logic   accept;
    logic   out_free;
    logic   commit;
    logic   is_add;
    bcast_t b;
    token_t chain [ENTRIES+1];

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign is_add   = (kind_reg == REQ_ADD);

    // The add is committed in the same cycle its response is loaded, and
    // only when the walk found no copy and at least one free entry.
    assign commit = (state_reg == ST_FINISH) && out_free && is_add && !hit_reg && free_reg;

    assign b.prune  = (kind_reg == REQ_PRUNE);
    assign b.commit = commit;
    assign b.value  = value_reg;

    assign chain[0].tok       = start_reg;
    assign chain[0].hit       = 1'b0;
    assign chain[0].free_seen = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ssrp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .b       (b),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = found_reg;
    assign rsp.full_drop = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            kind_reg      <= REQ_LOOKUP;
            value_reg     <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            start_reg <= accept;
            // A response taken while the next one is loaded stays valid, so
            // the finish state owns the flag in that cycle.
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= req.req_type;
                        value_reg <= req.slot_value;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (chain[ENTRIES].tok)
                    begin
                        hit_reg   <= chain[ENTRIES].hit;
                        free_reg  <= chain[ENTRIES].free_seen;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        drop_reg      <= is_add && !hit_reg && !free_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/ssrp_check.sv
// ============================================================================
// ssrp_check: port-level checks for the slot set
// Watches the request and response channels of the top level over time.
// ============================================================================
module ssrp_check (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic found,
    input logic full_drop
);

    // One request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // A dropped add can never have found the slot.
    a_drop_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(found && full_drop))
        else $error("response with both found and full_drop");

    // Acceptance leads into the chain walk, so no response rises right after a request.
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response rose one cycle after acceptance");

    // A stalled response holds its flags.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(full_drop))
        else $error("stalled response changed");

endmodule

bind slot_set_with_root_prune_core ssrp_check u_ssrp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .found     (rsp.found),
    .full_drop (rsp.full_drop)
);
